FILE: hw/rtl/terrain_tile_lighting_top_assert.svh
// Assertion macros used by the terrain tile lighting top level.
`ifndef TERRAIN_TILE_LIGHTING_TOP_ASSERT_SVH
`define TERRAIN_TILE_LIGHTING_TOP_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define TTL_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Condition implies consequence in the next cycle.
`define TTL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/ttl_pkg.sv
// Package with constants and types for the terrain tile lighting block.
package ttl_pkg;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_DIR_X    = 3'd0,
      CSR_DIR_Y    = 3'd1,
      CSR_DIR_Z    = 3'd2,
      CSR_AMBIENT  = 3'd3,
      CSR_DIVISOR  = 3'd4
   } csr_index_type;

   localparam int CSR_DATA_W = 16;

   // Register reset values.
   localparam logic signed [7:0] DIR_X_RESET   = -8'sd50;
   localparam logic signed [7:0] DIR_Y_RESET   = -8'sd10;
   localparam logic signed [7:0] DIR_Z_RESET   = -8'sd50;
   localparam logic [7:0]        AMBIENT_RESET = 8'd96;
   localparam logic [15:0]       DIVISOR_RESET = 16'd213;

   // Normal scale (unit normal squared) and the light clamp.
   localparam logic [16:0] NORM_SCALE = 17'd65536;
   localparam logic [7:0]  LIGHT_MAX  = 8'd255;

   // Normal components never exceed 256, so nine quotient bits do.
   localparam int NQ_W = 9;
   // Product, dot sum and final quotient widths.
   localparam int PROD_W = NQ_W + 1 + 8;
   localparam int DOT_W  = PROD_W + 1;
   localparam int MAG_W  = DOT_W - 1;

endpackage

FILE: hw/rtl/ttl_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module ttl_div_pipe #(
   parameter int NUM_W  = 18,
   parameter int DEN_W  = 16,
   parameter int QUO_W  = 18,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              en,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic [QUO_W-1:0]  quo,
   output logic [SIDE_W-1:0] side_out
);
   localparam int WIDE_W = NUM_W + QUO_W + DEN_W;

   logic [NUM_W-1:0]  rem_ff  [1:QUO_W];
   logic [QUO_W-1:0]  quo_ff  [1:QUO_W];
   logic [DEN_W-1:0]  den_ff  [1:QUO_W];
   logic [SIDE_W-1:0] side_ff [1:QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int BIT = QUO_W - 1 - k;
      logic [NUM_W-1:0]  rem_src;
      logic [QUO_W-1:0]  quo_src;
      logic [DEN_W-1:0]  den_src;
      logic [SIDE_W-1:0] side_src;
      logic [WIDE_W-1:0] trial;
      logic              take;
      logic [NUM_W-1:0]  rem_in;
      logic [QUO_W-1:0]  quo_in;

      // Pick the stage source: ports for the first stage.
      if (k == 0) begin : g_first
         assign rem_src  = num;
         assign quo_src  = '0;
         assign den_src  = den;
         assign side_src = side_in;
      end else begin : g_next
         assign rem_src  = rem_ff[k];
         assign quo_src  = quo_ff[k];
         assign den_src  = den_ff[k];
         assign side_src = side_ff[k];
      end

      // Try the shifted divisor and keep the difference when it fits.
      always_comb begin
         trial  = WIDE_W'(den_src) << BIT;
         take   = WIDE_W'(rem_src) >= trial;
         rem_in = take ? (rem_src - trial[NUM_W-1:0]) : rem_src;
         quo_in = quo_src | (QUO_W'(take) << BIT);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= rem_in;
            quo_ff[k+1]  <= quo_in;
            den_ff[k+1]  <= den_src;
            side_ff[k+1] <= side_src;
         end
      end
   end

   assign quo      = quo_ff[QUO_W];
   assign side_out = side_ff[QUO_W];

endmodule

FILE: hw/rtl/terrain_tile_lighting_top.sv
// Top level of the terrain tile lighting pipeline.
//
//   channel | ports                             | direction
//   req     | req_valid, req_stall, req_height_* | tile heights in
//   rsp     | rsp_valid, rsp_stall, rsp_light_value | brightness out
//   csr     | csr_wen, csr_index, csr_wdata     | register writes
//
// One item enters per cycle while the result is not stalled; the path runs through
// the bit-per-stage square root, the normal dividers and the final divider.
// Reset is synchronous; it clears valid bits and loads the configuration registers with their reset values.
// A stalled result freezes every stage at once, and req_stall follows it.
module terrain_tile_lighting_top #(
   parameter int HEIGHT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [HEIGHT_BITS-1:0] req_height_east,
   input  logic signed [HEIGHT_BITS-1:0] req_height_west,
   input  logic signed [HEIGHT_BITS-1:0] req_height_south,
   input  logic signed [HEIGHT_BITS-1:0] req_height_north,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_light_value,
   input  logic                          csr_wen,
   input  logic [2:0]                    csr_index,
   input  logic [ttl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ttl_pkg::*;
   `include "terrain_tile_lighting_top_assert.svh"

   localparam int HB   = HEIGHT_BITS;
   localparam int DW   = HB + 1;
   localparam int SQ_W = 2 * HB + 2;
   localparam int RW   = HB + 1;
   localparam int NW   = HB + 9;

   // Configuration registers.
   logic signed [7:0] dir_x_ff, dir_y_ff, dir_z_ff;
   logic [7:0]        ambient_ff;
   logic [15:0]       divisor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_x_ff   <= DIR_X_RESET;
         dir_y_ff   <= DIR_Y_RESET;
         dir_z_ff   <= DIR_Z_RESET;
         ambient_ff <= AMBIENT_RESET;
         divisor_ff <= DIVISOR_RESET;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_DIR_X:   dir_x_ff   <= csr_wdata[7:0];
            CSR_DIR_Y:   dir_y_ff   <= csr_wdata[7:0];
            CSR_DIR_Z:   dir_z_ff   <= csr_wdata[7:0];
            CSR_AMBIENT: ambient_ff <= csr_wdata[7:0];
            CSR_DIVISOR: divisor_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance all stages unless the held result is stalled.
   logic en;
   logic rsp_valid_ff;
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // Stage 1: height differences as sign and magnitude.
   logic          s1_v_ff, s1_sx_ff, s1_sz_ff;
   logic [HB-1:0] s1_ax_ff, s1_az_ff;
   logic signed [DW-1:0] dx, dz;

   always_comb begin
      dx = DW'(req_height_east) - DW'(req_height_west);
      dz = DW'(req_height_south) - DW'(req_height_north);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_sx_ff <= dx[DW-1];
         s1_sz_ff <= dz[DW-1];
         s1_ax_ff <= dx[DW-1] ? HB'(-dx) : HB'(dx);
         s1_az_ff <= dz[DW-1] ? HB'(-dz) : HB'(dz);
      end
   end

   // Stage 2: squares.
   logic            s2_v_ff, s2_sx_ff, s2_sz_ff;
   logic [HB-1:0]   s2_ax_ff, s2_az_ff;
   logic [2*HB-1:0] s2_x2_ff, s2_z2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_sx_ff <= s1_sx_ff;
         s2_sz_ff <= s1_sz_ff;
         s2_ax_ff <= s1_ax_ff;
         s2_az_ff <= s1_az_ff;
         s2_x2_ff <= (2*HB)'(s1_ax_ff) * (2*HB)'(s1_ax_ff);
         s2_z2_ff <= (2*HB)'(s1_az_ff) * (2*HB)'(s1_az_ff);
      end
   end

   // Stage 3: radicand, squares plus the normal scale.
   logic            s3_v_ff, s3_sx_ff, s3_sz_ff;
   logic [HB-1:0]   s3_ax_ff, s3_az_ff;
   logic [SQ_W-1:0] s3_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_sx_ff  <= s2_sx_ff;
         s3_sz_ff  <= s2_sz_ff;
         s3_ax_ff  <= s2_ax_ff;
         s3_az_ff  <= s2_az_ff;
         s3_sum_ff <= SQ_W'(s2_x2_ff) + SQ_W'(s2_z2_ff) + SQ_W'(NORM_SCALE);
      end
   end

   // Square root, one root bit per stage.
   logic            sq_v_ff    [1:RW];
   logic            sq_sx_ff   [1:RW];
   logic            sq_sz_ff   [1:RW];
   logic [HB-1:0]   sq_ax_ff   [1:RW];
   logic [HB-1:0]   sq_az_ff   [1:RW];
   logic [SQ_W-1:0] sq_rem_ff  [1:RW];
   logic [RW-1:0]   sq_root_ff [1:RW];

   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      localparam int BIT = RW - 1 - k;
      logic            v_src, sx_src, sz_src;
      logic [HB-1:0]   ax_src, az_src;
      logic [SQ_W-1:0] rem_src;
      logic [RW-1:0]   root_src;
      logic [SQ_W-1:0] trial;
      logic            take;

      if (k == 0) begin : g_first
         assign v_src    = s3_v_ff;
         assign sx_src   = s3_sx_ff;
         assign sz_src   = s3_sz_ff;
         assign ax_src   = s3_ax_ff;
         assign az_src   = s3_az_ff;
         assign rem_src  = s3_sum_ff;
         assign root_src = '0;
      end else begin : g_next
         assign v_src    = sq_v_ff[k];
         assign sx_src   = sq_sx_ff[k];
         assign sz_src   = sq_sz_ff[k];
         assign ax_src   = sq_ax_ff[k];
         assign az_src   = sq_az_ff[k];
         assign rem_src  = sq_rem_ff[k];
         assign root_src = sq_root_ff[k];
      end

      // Trial is 2*root*2^bit + 4^bit.
      always_comb begin
         trial = (SQ_W'(root_src) << (BIT + 1)) | (SQ_W'(1) << (2 * BIT));
         take  = rem_src >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else if (en) begin
            sq_v_ff[k+1] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_sx_ff[k+1]   <= sx_src;
            sq_sz_ff[k+1]   <= sz_src;
            sq_ax_ff[k+1]   <= ax_src;
            sq_az_ff[k+1]   <= az_src;
            sq_rem_ff[k+1]  <= take ? (rem_src - trial) : rem_src;
            sq_root_ff[k+1] <= root_src | (RW'(take) << BIT);
         end
      end
   end

   // Normal components: three dividers by the length.
   logic [NQ_W-1:0] qx, qy, qz;
   logic            nv, nsx, nsz;

   ttl_div_pipe #(
      .NUM_W (NW), .DEN_W (RW), .QUO_W (NQ_W), .SIDE_W (1)
   ) u_div_x (
      .clock    (clock),
      .en       (en),
      .num      (NW'({sq_ax_ff[RW], 8'd0})),
      .den      (sq_root_ff[RW]),
      .side_in  (sq_sx_ff[RW]),
      .quo      (qx),
      .side_out (nsx)
   );

   ttl_div_pipe #(
      .NUM_W (NW), .DEN_W (RW), .QUO_W (NQ_W), .SIDE_W (1)
   ) u_div_y (
      .clock    (clock),
      .en       (en),
      .num      (NW'(NORM_SCALE)),
      .den      (sq_root_ff[RW]),
      .side_in  (sq_v_ff[RW]),
      .quo      (qy),
      .side_out (nv)
   );

   ttl_div_pipe #(
      .NUM_W (NW), .DEN_W (RW), .QUO_W (NQ_W), .SIDE_W (1)
   ) u_div_z (
      .clock    (clock),
      .en       (en),
      .num      (NW'({sq_az_ff[RW], 8'd0})),
      .den      (sq_root_ff[RW]),
      .side_in  (sq_sz_ff[RW]),
      .quo      (qz),
      .side_out (nsz)
   );

   // Valid bits for the divider stages; the y divider carries them too.
   logic [NQ_W-1:0] nv_track_ff;
   logic            nv_ok;
   always_ff @(posedge clock) begin
      if (reset) begin
         nv_track_ff <= '0;
      end else if (en) begin
         nv_track_ff <= {nv_track_ff[NQ_W-2:0], sq_v_ff[RW]};
      end
   end
   assign nv_ok = nv_track_ff[NQ_W-1] && nv;

   // Products of the signed normal with the light direction.
   logic signed [NQ_W:0]     nx, ny, nz;
   logic signed [PROD_W-1:0] px_ff, py_ff, pz_ff;
   logic                     pv_ff;

   always_comb begin
      nx = nsx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      ny = $signed({1'b0, qy});
      nz = nsz ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (en) begin
         pv_ff <= nv_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= PROD_W'(nx) * PROD_W'(dir_x_ff);
         py_ff <= PROD_W'(ny) * PROD_W'(dir_y_ff);
         pz_ff <= PROD_W'(nz) * PROD_W'(dir_z_ff);
      end
   end

   // Dot product as sign and magnitude.
   logic                    dv_ff, dsign_ff;
   logic [MAG_W-1:0]        dmag_ff;
   logic signed [DOT_W-1:0] dot;

   assign dot = DOT_W'(px_ff) + DOT_W'(py_ff) + DOT_W'(pz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= 1'b0;
      end else if (en) begin
         dv_ff <= pv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dsign_ff <= dot[DOT_W-1];
         dmag_ff  <= dot[DOT_W-1] ? MAG_W'(-dot) : MAG_W'(dot);
      end
   end

   // Divide by the intensity divisor; zero acts as one.
   logic [15:0]      div_den;
   logic [MAG_W-1:0] fq;
   logic             fsign;

   assign div_den = (divisor_ff == '0) ? 16'd1 : divisor_ff;

   ttl_div_pipe #(
      .NUM_W (MAG_W), .DEN_W (16), .QUO_W (MAG_W), .SIDE_W (1)
   ) u_div_light (
      .clock    (clock),
      .en       (en),
      .num      (dmag_ff),
      .den      (div_den),
      .side_in  (dsign_ff),
      .quo      (fq),
      .side_out (fsign)
   );

   // Valid bits for the final divider stages, cleared by reset.
   logic [MAG_W-1:0] lv_track_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         lv_track_ff <= '0;
      end else if (en) begin
         lv_track_ff <= {lv_track_ff[MAG_W-2:0], dv_ff};
      end
   end

   // Add ambient, clamp and hold the result.
   logic signed [MAG_W+1:0] lit;
   logic [7:0]              light_in;
   logic [7:0]              rsp_light_ff;

   always_comb begin
      lit = fsign ? -$signed((MAG_W+2)'(fq)) : $signed((MAG_W+2)'(fq));
      lit = lit + $signed((MAG_W+2)'(ambient_ff));
      if (lit < 0) begin
         light_in = 8'd0;
      end else if (lit > $signed((MAG_W+2)'(LIGHT_MAX))) begin
         light_in = LIGHT_MAX;
      end else begin
         light_in = lit[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= lv_track_ff[MAG_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_light_ff <= light_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_light_value = rsp_light_ff;

   `TTL_ASSERT_IMPLIES(a_len_floor, sq_v_ff[RW], sq_root_ff[RW] >= 256, "normal length below 256")
   `TTL_ASSERT_IMPLIES(a_norm_range, nv_ok, (qx <= 256) && (qy <= 256) && (qz <= 256), "bad normal")
   `TTL_ASSERT_IMPLIES(a_valid_track, nv_track_ff[NQ_W-1] == 1'b1, nv, "divider valid lost")
   `TTL_ASSERT_NEXT(a_result_load, en && lv_track_ff[MAG_W-1], rsp_valid_ff, "item not loaded")

endmodule
